// ===== hdl/mos_pkg.sv =====
// Shared types and constants for the magnitude order sorter.
// No dependencies.
package mos_pkg;

  // Kept samples per run and store geometry
  localparam int unsigned MaxLen  = 64;
  localparam int unsigned AddrW   = 6;
  localparam int unsigned Depth   = 2 ** AddrW;
  localparam int unsigned CntW    = AddrW + 1;
  localparam int unsigned SampleW = 16;
  localparam int unsigned MagW    = SampleW + 1;

  localparam logic [CntW-1:0] MaxLenC = CntW'(MaxLen);

  // One store entry: sample and its position in the run
  typedef struct packed {
    logic signed [SampleW-1:0] value;
    logic [AddrW-1:0]          index;
  } entry_t;

  // Absolute value; -32768 maps to 32768
  function automatic logic [MagW-1:0] magnitude(logic [SampleW-1:0] v);
    logic [MagW-1:0] e;
    e = {v[SampleW-1], v};
    return v[SampleW-1] ? (MagW'(0) - e) : e;
  endfunction

endpackage

// ===== hdl/magnitude_order_sorter.sv =====
// Top level of the magnitude order sorter: sequencer around the entry store.
// Depends on mos_pkg and mos_store.
//
//  channel  | signals                                  | handshake
//  ---------+------------------------------------------+--------------------------
//  input    | sample_i, is_last_i                      | start high, busy low
//  result   | sorted_value_o, original_index_o,        | valid_o strobe, one cycle,
//           | last_out_o, overflow_o                   | always taken
//
// Each item is inserted into a store kept sorted by falling magnitude: the
// insertion walks from the tail, one entry per cycle through the store's
// read-compare-write loop, passing at most 63 entries. The first item of a
// run and a dropped item are handled in the idle state alone. After the last
// item the run is read out at one result per cycle. Reset clears only the
// state, fill count and flags; the store needs no clearing pass. The receiver
// cannot stall; busy is high during insertion and read-out.
module magnitude_order_sorter
  import mos_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [SampleW-1:0] sample_i,
  input  logic                      is_last_i,
  output logic                      valid_o,
  output logic signed [SampleW-1:0] sorted_value_o,
  output logic [AddrW-1:0]          original_index_o,
  output logic                      last_out_o,
  output logic                      overflow_o
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SHIFT = 4'b0010,
    ST_PLACE = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic [CntW-1:0]  fill_q, fill_d;
  logic             ovf_q, ovf_d;
  logic [AddrW-1:0] pos_q, pos_d;
  logic [AddrW-1:0] ptr_q, ptr_d;
  entry_t           new_q, new_d;
  logic             last_q, last_d;
  logic             valid_q, valid_d;
  logic             last_out_q, last_out_d;
  logic             ovf_out_q, ovf_out_d;

  logic             we;
  logic [AddrW-1:0] waddr;
  entry_t           wdata;
  logic             re;
  logic [AddrW-1:0] raddr;
  entry_t           rdata;

  mos_store u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // sequencer
  always_comb begin
    state_d    = state_q;
    fill_d     = fill_q;
    ovf_d      = ovf_q;
    pos_d      = pos_q;
    ptr_d      = ptr_q;
    new_d      = new_q;
    last_d     = last_q;
    valid_d    = 1'b0;
    last_out_d = 1'b0;
    ovf_out_d  = 1'b0;
    we         = 1'b0;
    waddr      = pos_q;
    wdata      = new_q;
    re         = 1'b0;
    raddr      = pos_q - AddrW'(1);

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          if (fill_q < MaxLenC) begin
            new_d.value = sample_i;
            new_d.index = fill_q[AddrW-1:0];
            last_d      = is_last_i;
            pos_d       = fill_q[AddrW-1:0];
            if (fill_q == '0) begin
              // empty store: place directly at the head
              we          = 1'b1;
              waddr       = '0;
              wdata.value = sample_i;
              wdata.index = '0;
              fill_d      = CntW'(1);
              ptr_d       = '0;
              state_d     = is_last_i ? ST_EMIT : ST_IDLE;
            end else begin
              re      = 1'b1;
              raddr   = fill_q[AddrW-1:0] - AddrW'(1);
              state_d = ST_SHIFT;
            end
          end else begin
            // store full: drop the item
            ovf_d   = 1'b1;
            ptr_d   = '0;
            state_d = is_last_i ? ST_EMIT : ST_IDLE;
          end
        end
      end

      ST_SHIFT: begin
        // rdata holds entry pos_q - 1
        if (magnitude(rdata.value) < magnitude(new_q.value)) begin
          we    = 1'b1;
          wdata = rdata;
          pos_d = pos_q - AddrW'(1);
          if (pos_q == AddrW'(1)) begin
            state_d = ST_PLACE;
          end else begin
            re    = 1'b1;
            raddr = pos_q - AddrW'(2);
          end
        end else begin
          we      = 1'b1;
          fill_d  = fill_q + CntW'(1);
          ptr_d   = '0;
          state_d = last_q ? ST_EMIT : ST_IDLE;
        end
      end

      ST_PLACE: begin
        we      = 1'b1;
        fill_d  = fill_q + CntW'(1);
        ptr_d   = '0;
        state_d = last_q ? ST_EMIT : ST_IDLE;
      end

      ST_EMIT: begin
        re        = 1'b1;
        raddr     = ptr_q;
        valid_d   = 1'b1;
        ovf_out_d = ovf_q;
        if ({1'b0, ptr_q} == fill_q - CntW'(1)) begin
          last_out_d = 1'b1;
          fill_d     = '0;
          ovf_d      = 1'b0;
          state_d    = ST_IDLE;
        end else begin
          ptr_d = ptr_q + AddrW'(1);
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      fill_q     <= '0;
      ovf_q      <= 1'b0;
      valid_q    <= 1'b0;
      last_out_q <= 1'b0;
      ovf_out_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      fill_q     <= fill_d;
      ovf_q      <= ovf_d;
      valid_q    <= valid_d;
      last_out_q <= last_out_d;
      ovf_out_q  <= ovf_out_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    pos_q  <= pos_d;
    ptr_q  <= ptr_d;
    new_q  <= new_d;
    last_q <= last_d;
  end

  assign busy             = (state_q != ST_IDLE);
  assign valid_o          = valid_q;
  assign sorted_value_o   = rdata.value;
  assign original_index_o = rdata.index;
  assign last_out_o       = last_out_q;
  assign overflow_o       = ovf_out_q;

`ifndef ASSERT_OFF
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= MaxLenC)
    else $error("fill count beyond capacity");

  a_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !last_out_o) |=> valid_o)
    else $error("gap inside a result burst");

  a_last_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (last_out_o || overflow_o) |-> valid_o)
    else $error("result flag without strobe");

  a_run_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_out_o |-> (fill_q == '0 && !ovf_q))
    else $error("run state not cleared after final result");
`endif

endmodule

// ===== hdl/mos_store.sv =====
// Entry store of the sorter: one write port, one read port, registered read.
// Depends on mos_pkg.
module mos_store
  import mos_pkg::*;
(
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  entry_t           wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output entry_t           rdata_o
);

  entry_t mem [Depth];
  entry_t rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, registered
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== tb/tb_top.sv =====
// Testbench for magnitude_order_sorter: random and directed sample series,
// checked result by result against a built-in stable magnitude sort.
// Depends on mos_pkg and the magnitude_order_sorter RTL.
module tb_top;

  localparam int SW = mos_pkg::SampleW;
  localparam int AW = mos_pkg::AddrW;
  localparam int KEEP = mos_pkg::MaxLen;
  localparam int DEPTH = mos_pkg::Depth;
  localparam int DRAIN_CYCLES = 70;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TARGET_ITEMS = 480;

  // One series sample as sent to the block
  typedef struct packed {
    logic signed [SW-1:0] sample;
    logic                 is_last;
  } series_item_t;

  // One sorted result as the block should emit it
  typedef struct packed {
    logic signed [SW-1:0] value;
    logic [AW-1:0]        index;
    logic                 last;
    logic                 ovf;
  } ranked_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic signed [SW-1:0] sample_i = '0;
  logic                 is_last_i = 1'b0;
  logic                 valid_o;
  logic signed [SW-1:0] sorted_value_o;
  logic [AW-1:0]        original_index_o;
  logic                 last_out_o;
  logic                 overflow_o;

  series_item_t series_q[$];
  ranked_t      sorted_due_q[$];
  int           total_items = 0;
  int           sent_cnt = 0;
  int           taken_cnt = 0;
  int           err_count = 0;
  int           cycle_count = 0;

  // Shadow of the block's store for the current run
  logic signed [SW-1:0] kept_value[DEPTH];
  logic [AW-1:0]        kept_index[DEPTH];
  int                   kept_fill = 0;
  bit                   run_dropped = 1'b0;

  magnitude_order_sorter u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .sample_i        (sample_i),
    .is_last_i       (is_last_i),
    .valid_o         (valid_o),
    .sorted_value_o  (sorted_value_o),
    .original_index_o(original_index_o),
    .last_out_o      (last_out_o),
    .overflow_o      (overflow_o)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  function automatic int abs_level(logic signed [SW-1:0] v);
    return (v < 0) ? -int'(v) : int'(v);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch at cycle %0d: %s got %0d, want %0d", cycle_count, what, got, want);
    err_count++;
  endtask

  // Keep the sample; on the last one, sort the run and queue the results
  task automatic absorb_sample(logic signed [SW-1:0] s, logic last);
    logic signed [SW-1:0] vals[DEPTH];
    logic [AW-1:0]        idxs[DEPTH];
    ranked_t              r;
    int                   j;
    if (kept_fill < KEEP) begin
      kept_value[kept_fill] = s;
      kept_index[kept_fill] = AW'(kept_fill);
      kept_fill++;
    end else begin
      run_dropped = 1'b1;
    end
    if (last) begin
      // stable insertion sort, largest magnitude first
      for (int i = 0; i < kept_fill; i++) begin
        j = i;
        while (j > 0 && abs_level(vals[j-1]) < abs_level(kept_value[i])) begin
          vals[j] = vals[j-1];
          idxs[j] = idxs[j-1];
          j--;
        end
        vals[j] = kept_value[i];
        idxs[j] = kept_index[i];
      end
      for (int i = 0; i < kept_fill; i++) begin
        r.value = vals[i];
        r.index = idxs[i];
        r.last  = (i == kept_fill - 1);
        r.ovf   = run_dropped;
        sorted_due_q.push_back(r);
      end
      kept_fill   = 0;
      run_dropped = 1'b0;
    end
  endtask

  task automatic push_item(logic signed [SW-1:0] s, logic last);
    series_item_t it;
    it.sample  = s;
    it.is_last = last;
    series_q.push_back(it);
    total_items++;
  endtask

  // Mix of extremes, tie-prone small values and full-range noise
  function automatic logic signed [SW-1:0] pick_sample();
    logic signed [SW-1:0] t;
    case ($urandom_range(0, 9))
      0: t = {1'b1, {(SW-1){1'b0}}};
      1: t = {1'b0, {(SW-1){1'b1}}};
      2: t = {1'b1, {(SW-2){1'b0}}, 1'b1};
      3, 4: begin
        t = SW'($urandom_range(0, 3));
        if ($urandom_range(0, 1) == 1) t = -t;
      end
      default: t = SW'($urandom());
    endcase
    return t;
  endfunction

  task automatic push_run(int len);
    for (int i = 0; i < len; i++) push_item(pick_sample(), i == len - 1);
  endtask

  // Sender idle rate by stage of the run
  function automatic int idle_pct();
    if (sent_cnt < total_items / 3) return 37;
    if (sent_cnt < (2 * total_items) / 3) return 78;
    return 0;
  endfunction

  // Driver: present items at the falling edge, hold until taken
  always @(negedge clk_i) begin
    series_item_t it;
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (start && taken_cnt != sent_cnt) begin
      // still waiting for the block to take the item
    end else if (series_q.size() != 0 && $urandom_range(0, 99) >= idle_pct()) begin
      it = series_q.pop_front();
      start     <= 1'b1;
      sample_i  <= it.sample;
      is_last_i <= it.is_last;
      sent_cnt++;
    end else begin
      start     <= 1'b0;
      sample_i  <= SW'($urandom());
      is_last_i <= 1'($urandom_range(0, 1));
    end
  end

  // Monitor: check results and record taken items at the rising edge
  always @(posedge clk_i) begin
    ranked_t want;
    if (rst_ni) begin
      if (valid_o) begin
        if (sorted_due_q.size() == 0) begin
          report_mismatch("unexpected result, value", int'(sorted_value_o), 0);
        end else begin
          want = sorted_due_q.pop_front();
          if (sorted_value_o !== want.value)
            report_mismatch("sorted_value", int'(sorted_value_o), int'(want.value));
          if (original_index_o !== want.index)
            report_mismatch("original_index", int'(original_index_o), int'(want.index));
          if (last_out_o !== want.last)
            report_mismatch("last_out", int'(last_out_o), int'(want.last));
          if (overflow_o !== want.ovf)
            report_mismatch("overflow", int'(overflow_o), int'(want.ovf));
        end
      end
      if (start && !busy) begin
        absorb_sample(sample_i, is_last_i);
        taken_cnt++;
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int runs;
    int sel;
    // single sample, most negative value
    push_item(16'sh8000, 1'b1);
    // extremes, equal magnitudes of both signs, zeros
    push_item(16'sh7FFF, 1'b0);
    push_item(16'sh8000, 1'b0);
    push_item(16'sh0000, 1'b0);
    push_item(-16'sd1, 1'b0);
    push_item(16'sd1, 1'b0);
    push_item(-16'sd32767, 1'b0);
    push_item(16'sh7FFF, 1'b0);
    push_item(16'sd5, 1'b0);
    push_item(-16'sd5, 1'b0);
    push_item(16'sh0000, 1'b1);
    // all ties
    push_item(16'sd3, 1'b0);
    push_item(16'sd3, 1'b0);
    push_item(-16'sd3, 1'b0);
    push_item(16'sd3, 1'b1);
    // alternating bit patterns
    push_item(16'sh5555, 1'b0);
    push_item(16'shAAAA, 1'b0);
    push_item(16'sd100, 1'b1);

    // random runs: a full store, then one that drops the last two samples
    runs = 0;
    while (total_items < TARGET_ITEMS) begin
      if (runs == 0) begin
        push_run(KEEP);
      end else if (runs == 1) begin
        push_run(KEEP + 2);
      end else begin
        sel = $urandom_range(0, 99);
        if (sel < 2) push_run(KEEP - 1);
        else if (sel < 4) push_run(KEEP + 1);
        else if (sel < 6) push_run(KEEP + $urandom_range(2, 10));
        else push_run($urandom_range(1, 12));
      end
      runs++;
    end

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (taken_cnt < total_items) @(posedge clk_i);
    while (sorted_due_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
